// ----- hdl/double_ended_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue checker
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define DEQ_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define DEQ_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hdl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Field widths, action codes and status codes of the double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	localparam int ACT_W = 3;
	localparam int VAL_W = 32;
	localparam int STS_W = 2;

	// Action codes; 6 and 7 are ignored
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_LIST_FWD   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_LIST_BWD   = 3'd5;

	// Result status codes
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/deq_req_if.sv -----
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: action and value, with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if;
	import deq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic signed [VAL_W-1:0] value;

	modport source  (output valid, action, value, input ready);
	modport sink    (input valid, action, value, output ready);
	modport monitor (input valid, ready, action, value);
endinterface

`default_nettype wire

// ----- hdl/deq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// deq_rsp_if
// Result channel: value_out, status and last, with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface deq_rsp_if;
	import deq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value_out;
	logic [STS_W-1:0]        status;
	logic                    last;

	modport source  (output valid, value_out, status, last, input ready);
	modport sink    (input valid, value_out, status, last, output ready);
	modport monitor (input valid, ready, value_out, status, last);
endinterface

`default_nettype wire

// ----- hdl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue over a circular store addressed by front index and count.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                    Results per item
//  req      in   action, value              -
//  rsp      out  value_out, status, last    push/empty: 1, pop: 1, list: count
//
//  Push, full push and empty pop/list: result is loaded straight into the
//  output register on accept; ignored actions give no result.
//  Pop: the store read data is registered, then loaded into the output register.
//  List of N elements: one read of the store per cycle while rsp does not stall.
//  req.ready is low while a pop or list drains and while rsp stalls.
//  Reset clears front index, count and control; the store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   front_q;
	logic [CW-1:0]   occ_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   s_q;
	logic            back_q;
	logic            rv_q;
	logic            ov_q;
	logic [VAL_W-1:0] out_val_q;
	logic [STS_W-1:0] out_sts_q;
	logic            out_last_q;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic                  re;
	logic [AW-1:0]         raddr;
	logic [DATA_WIDTH-1:0] rdata;

	logic            can_load;
	logic            accept;
	logic            full;
	logic            empty;
	logic            is_back;
	logic [CW-1:0]   rd_off;
	logic            busy_load;
	logic            busy_issue;
	logic            busy_last;

	// Input value into store width
	function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [VAL_W-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		return e[DATA_WIDTH-1:0];
	endfunction

	// Stored value back to the 32-bit result field
	function automatic logic [VAL_W-1:0] to_out(input logic [DATA_WIDTH-1:0] d);
		logic signed [DATA_WIDTH-1:0] ds;
		logic signed [63:0]           e;
		ds = d;
		e  = 64'(ds);
		return e[VAL_W-1:0];
	endfunction

	// (front + offset) mod DEPTH, both operands below DEPTH
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(f) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	deq_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Handshake and status
	assign can_load  = !ov_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && can_load;
	assign accept    = req.valid && req.ready;
	assign full      = (occ_q == CW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign is_back   = (req.action == ACT_POP_BACK) || (req.action == ACT_LIST_BWD);

	// Drain side: one read issued per cycle, interlocked with the output register
	assign busy_load  = (state_q == ST_BUSY) && rv_q && can_load;
	assign busy_issue = (state_q == ST_BUSY) && (i_q < n_q) && (!rv_q || busy_load);
	assign busy_last  = ((s_q + CW'(1)) == n_q);

	// Store write on an accepted push that fits
	always_comb begin
		we    = 1'b0;
		waddr = slot(front_q, occ_q);
		wdata = to_store(req.value);
		if (accept && !full) begin
			case (req.action)
				ACT_PUSH_FRONT: begin
					we    = 1'b1;
					waddr = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
				end
				ACT_PUSH_BACK: begin
					we = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Store read: first element on accept, the rest while draining
	always_comb begin
		re     = 1'b0;
		rd_off = back_q ? (n_q - CW'(1) - i_q) : i_q;
		if (state_q == ST_IDLE) begin
			rd_off = is_back ? (occ_q - CW'(1)) : '0;
			if (accept && !empty) begin
				case (req.action)
					ACT_POP_FRONT, ACT_POP_BACK, ACT_LIST_FWD, ACT_LIST_BWD: re = 1'b1;
					default: ;
				endcase
			end
		end else begin
			re = busy_issue;
		end
		raddr = slot(front_q, rd_off);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			occ_q   <= '0;
			n_q     <= '0;
			i_q     <= '0;
			s_q     <= '0;
			back_q  <= 1'b0;
			rv_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.action)
							ACT_PUSH_FRONT: begin
								if (!full) begin
									front_q <= waddr;
									occ_q   <= occ_q + CW'(1);
								end
							end
							ACT_PUSH_BACK: begin
								if (!full) begin
									occ_q <= occ_q + CW'(1);
								end
							end
							ACT_POP_FRONT, ACT_POP_BACK: begin
								if (!empty) begin
									if (req.action == ACT_POP_FRONT) begin
										front_q <= slot(front_q, CW'(1));
									end
									occ_q   <= occ_q - CW'(1);
									n_q     <= CW'(1);
									i_q     <= CW'(1);
									s_q     <= '0;
									back_q  <= 1'b0;
									rv_q    <= 1'b1;
									state_q <= ST_BUSY;
								end
							end
							ACT_LIST_FWD, ACT_LIST_BWD: begin
								if (!empty) begin
									n_q     <= occ_q;
									i_q     <= CW'(1);
									s_q     <= '0;
									back_q  <= is_back;
									rv_q    <= 1'b1;
									state_q <= ST_BUSY;
								end
							end
							default: ;
						endcase
					end
				end
				ST_BUSY: begin
					if (busy_issue) begin
						i_q  <= i_q + CW'(1);
						rv_q <= 1'b1;
					end else if (busy_load) begin
						rv_q <= 1'b0;
					end
					if (busy_load) begin
						s_q <= s_q + CW'(1);
						if (busy_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (busy_load) begin
			ov_q <= 1'b1;
		end else if (accept) begin
			case (req.action)
				ACT_PUSH_FRONT, ACT_PUSH_BACK: ov_q <= 1'b1;
				ACT_POP_FRONT, ACT_POP_BACK, ACT_LIST_FWD, ACT_LIST_BWD: ov_q <= empty;
				default: ov_q <= 1'b0;
			endcase
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (busy_load) begin
			out_val_q  <= to_out(rdata);
			out_sts_q  <= STS_OK;
			out_last_q <= busy_last;
		end else if (accept) begin
			out_last_q <= 1'b1;
			case (req.action)
				ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
					out_val_q <= to_out(to_store(req.value));
					out_sts_q <= full ? STS_FULL : STS_OK;
				end
				default: begin
					out_val_q <= '0;
					out_sts_q <= STS_EMPTY;
				end
			endcase
		end
	end

	assign rsp.valid     = ov_q;
	assign rsp.value_out = out_val_q;
	assign rsp.status    = out_sts_q;
	assign rsp.last      = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// deq_ram
// Element store: one write port, one read port with registered read data.
// Read data holds until the next read enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(DEPTH)-1:0]      waddr,
	input  wire logic [DATA_WIDTH-1:0]         wdata,
	input  wire logic                          re,
	input  wire logic [$clog2(DEPTH)-1:0]      raddr,
	output logic      [DATA_WIDTH-1:0]         rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/deq_chk.sv -----
// ----------------------------------------------------------------------------
// deq_chk
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_assert.svh"

module deq_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_ready,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire logic [deq_pkg::VAL_W-1:0] rsp_value_out,
	input wire logic [deq_pkg::STS_W-1:0] rsp_status,
	input wire logic                      rsp_last
);
	import deq_pkg::*;

	logic                   rsp_stall;
	logic                   rsp_empty;
	logic                   sts_legal;
	logic [VAL_W+STS_W:0]   rsp_payload;

	assign rsp_stall   = rsp_valid && !rsp_ready;
	assign rsp_empty   = rsp_valid && (rsp_status == STS_EMPTY);
	assign rsp_payload = {rsp_value_out, rsp_status, rsp_last};
	// Full results are single; ok and empty are the other defined codes
	assign sts_legal   = (rsp_status == STS_OK) || (rsp_status == STS_EMPTY) ||
		((rsp_status == STS_FULL) && rsp_last);

	// A stalled result keeps its payload
	`DEQ_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "held result changed")

	// No new request while a listing is still in flight
	`DEQ_ASSERT_IMP(a_mid_list_block, rsp_valid && !rsp_last, !req_ready, "request mid listing")

	// Empty result carries zero and closes the item
	`DEQ_ASSERT_IMP(a_empty_form, rsp_empty, (rsp_value_out == '0) && rsp_last, "malformed empty result")

	// Status code is defined
	`DEQ_ASSERT_IMP(a_status_form, rsp_valid, sts_legal, "bad result status")

endmodule

bind double_ended_queue deq_chk u_deq_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_value_out (rsp.value_out),
	.rsp_status    (rsp.status),
	.rsp_last      (rsp.last)
);

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: double_ended_queue testbench
// Feeds push, pop and list requests through the request channel and scores
// every result against a shadow deque kept in the testbench. The sender
// works in random bursts and the result side stalls in changing patterns.
// ----------------------------------------------------------------------------

module tb;
	import deq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

	// Actions the block must ignore
	localparam logic [ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_UNUSED_7 = 3'd7;

	typedef struct {
		logic signed [VAL_W-1:0] value_out;
		logic [STS_W-1:0]        status;
		logic                    last;
	} deq_result_t;

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PATTERN} stall_mode_t;
	typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED} episode_t;

	logic clk = 1'b0;
	logic arst_n;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (VAL_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow deque and the results it predicts
	logic signed [VAL_W-1:0] shadow_store [DEPTH];
	int                      shadow_front;
	int                      shadow_count;
	deq_result_t             pending_rsp [$];

	int burst_left;
	int error_count;
	int items_sent;
	int ignored_items;
	int results_checked;
	int full_pushes;
	int empty_hits;
	int idle_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void queue_result(input logic signed [VAL_W-1:0] v,
			input logic [STS_W-1:0] sts, input logic lst);
		deq_result_t r;
		r.value_out = v;
		r.status    = sts;
		r.last      = lst;
		pending_rsp.push_back(r);
	endfunction

	// Update the shadow deque for one accepted item and queue its results
	task automatic apply_deque_op(input logic [ACT_W-1:0] act,
			input logic signed [VAL_W-1:0] val);
		int k;
		int off;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					queue_result(val, STS_FULL, 1'b1);
					full_pushes++;
				end else begin
					if (act == ACT_PUSH_FRONT) begin
						shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
						shadow_store[shadow_front] = val;
					end else begin
						shadow_store[(shadow_front + shadow_count) % DEPTH] = val;
					end
					shadow_count++;
					queue_result(val, STS_OK, 1'b1);
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (shadow_count == 0) begin
					queue_result('0, STS_EMPTY, 1'b1);
					empty_hits++;
				end else if (act == ACT_POP_FRONT) begin
					queue_result(shadow_store[shadow_front], STS_OK, 1'b1);
					shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
				end else begin
					queue_result(shadow_store[(shadow_front + shadow_count - 1) % DEPTH],
						STS_OK, 1'b1);
					shadow_count--;
				end
			end
			ACT_LIST_FWD, ACT_LIST_BWD: begin
				if (shadow_count == 0) begin
					queue_result('0, STS_EMPTY, 1'b1);
					empty_hits++;
				end else begin
					for (k = 0; k < shadow_count; k++) begin
						off = (act == ACT_LIST_FWD) ? k : shadow_count - 1 - k;
						queue_result(shadow_store[(shadow_front + off) % DEPTH], STS_OK,
							k == shadow_count - 1);
					end
				end
			end
			default: ignored_items++;
		endcase
	endtask

	// Send one item; a new burst may start with a gap
	task automatic send_item(input logic [ACT_W-1:0] act,
			input logic signed [VAL_W-1:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.value  <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_sent++;
		apply_deque_op(act, val);
	endtask

	// Mostly random values, with the corners mixed in
	function automatic logic signed [VAL_W-1:0] pick_value();
		logic signed [VAL_W-1:0] v;
		case ($urandom_range(0, 7))
			0:       v = {1'b1, {(VAL_W-1){1'b0}}};
			1:       v = {1'b0, {(VAL_W-1){1'b1}}};
			2:       v = '1;
			3:       v = '0;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Pops, lists and unused actions on an empty queue
	task automatic test_empty_queue();
		send_item(ACT_POP_FRONT, pick_value());
		send_item(ACT_POP_BACK, pick_value());
		send_item(ACT_LIST_FWD, pick_value());
		send_item(ACT_LIST_BWD, pick_value());
		send_item(ACT_UNUSED_6, pick_value());
		send_item(ACT_UNUSED_7, pick_value());
	endtask

	// Extreme values at both ends, front index wraps below zero
	task automatic test_value_extremes();
		send_item(ACT_PUSH_FRONT, 32'sh8000_0000);
		send_item(ACT_PUSH_BACK, 32'sh7fff_ffff);
		send_item(ACT_PUSH_FRONT, -32'sd1);
		send_item(ACT_PUSH_BACK, 32'sh0000_0000);
		send_item(ACT_LIST_FWD, 32'sh5555_5555);
		send_item(ACT_LIST_BWD, 32'shaaaa_aaaa);
		send_item(ACT_POP_BACK, pick_value());
		send_item(ACT_POP_FRONT, pick_value());
		send_item(ACT_POP_FRONT, pick_value());
		send_item(ACT_POP_BACK, pick_value());
	endtask

	// Fill to capacity, push into a full queue at both ends, list it
	task automatic test_full_queue();
		int k;
		for (k = 0; k < DEPTH; k++)
			send_item($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value());
		send_item(ACT_PUSH_FRONT, pick_value());
		send_item(ACT_PUSH_BACK, pick_value());
		send_item(ACT_LIST_FWD, pick_value());
		send_item(ACT_LIST_BWD, pick_value());
	endtask

	// Random episodes that lean toward filling, draining or neither
	task automatic test_random_mix(input int n_items);
		int               done;
		int               ep_left;
		int               roll;
		int               push_pct;
		episode_t         kind;
		logic [ACT_W-1:0] act;
		done    = 0;
		ep_left = 0;
		kind    = EP_MIXED;
		while (done < n_items) begin
			if (ep_left == 0) begin
				kind    = episode_t'($urandom_range(0, 2));
				ep_left = $urandom_range(6, 24);
			end
			ep_left--;
			push_pct = (kind == EP_FILL) ? 80 : (kind == EP_DRAIN) ? 15 : 50;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				act = $urandom_range(0, 1) ? ACT_UNUSED_6 : ACT_UNUSED_7;
			else if (roll < 12)
				act = $urandom_range(0, 1) ? ACT_LIST_FWD : ACT_LIST_BWD;
			else if ($urandom_range(0, 99) < push_pct)
				act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
			else
				act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
			send_item(act, pick_value());
			if (act != ACT_UNUSED_6 && act != ACT_UNUSED_7)
				done++;
		end
	endtask

	// Result-side stalls in one of four modes, picked anew at random
	initial begin : rsp_stall_pattern
		stall_mode_t mode;
		int          left;
		logic [7:0]  pat;
		rsp_ch.ready = 1'b0;
		mode = RDY_ALWAYS;
		left = 0;
		pat  = 8'b1101_0110;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 80);
			end
			left--;
			pat = {pat[6:0], pat[7]};
			case (mode)
				RDY_ALWAYS: rsp_ch.ready <= 1'b1;
				RDY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default:    rsp_ch.ready <= pat[0];
			endcase
		end
	end

	// Score each accepted result against the oldest prediction
	always @(posedge clk) begin : check_results
		deq_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_checked++;
			if (pending_rsp.size() == 0) begin
				$error("unexpected result: value_out %0d status %0d last %0d",
					rsp_ch.value_out, rsp_ch.status, rsp_ch.last);
				error_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.value_out !== want.value_out) begin
					$error("value_out: expected %0d, actual %0d", want.value_out,
						rsp_ch.value_out);
					error_count++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles where neither channel moves an item
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	initial begin
		req_ch.valid    = 1'b0;
		req_ch.action   = ACT_PUSH_FRONT;
		req_ch.value    = '0;
		arst_n          = 1'b0;
		shadow_front    = 0;
		shadow_count    = 0;
		burst_left      = 0;
		error_count     = 0;
		items_sent      = 0;
		ignored_items   = 0;
		results_checked = 0;
		full_pushes     = 0;
		empty_hits      = 0;
		idle_cycles     = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_value_extremes();
		test_full_queue();
		test_random_mix(115);
		req_ch.valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d with unused actions), checked %0d results",
			items_sent, ignored_items, results_checked);
		$display("Pushes into a full queue: %0d, pops or lists on empty: %0d",
			full_pushes, empty_hits);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_req_if.sv
hdl/deq_rsp_if.sv
hdl/deq_ram.sv
hdl/double_ended_queue.sv
hdl/deq_chk.sv
test/tb.sv
